// File: rtl/coap_dedup_message_cache_unit_macros.svh
// Assertion macros for the deduplication cache checker.
`ifndef COAP_DEDUP_MESSAGE_CACHE_UNIT_MACROS_SVH
`define COAP_DEDUP_MESSAGE_CACHE_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// File: rtl/cdc_pkg.sv
// Shared types and constants of the deduplication cache.
package cdc_pkg;
  localparam int BufferBytes = 4096;
  localparam int MaxRecords = 64;
  localparam int RecordOverhead = 24;
  localparam int AlignBytes = 8;
  localparam int LengthFieldBytes = 4;
  localparam int SlotW = $clog2(MaxRecords);
  localparam int CountW = $clog2(MaxRecords + 1);
  localparam int BytesW = $clog2(BufferBytes + 1);
  localparam int CostW = 14;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StDuplicate = 3'd1;
  localparam logic [2:0] StTooLarge = 3'd2;
  localparam logic [2:0] StHit = 3'd3;
  localparam logic [2:0] StMiss = 3'd4;

  // Content of one cell of the record chain.
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] expiry;
    logic [CostW-1:0] cost;
  } rec_t;

  // Commands from the controller to the chain.
  typedef struct packed {
    logic pop;      // shift toward head, dropping cell 0
    logic push;     // write new record at the tail position
    logic rotate;   // rotate one position for the search
    logic [CountW-1:0] count;
    rec_t rec;
  } chain_ctl_t;
endpackage

// File: rtl/cdc_cell.sv
// One cell of the record chain: holds one record and takes its neighbor's.
module cdc_cell import cdc_pkg::*; (
  input  logic clk,
  input  logic load,
  input  rec_t d,
  output rec_t q
);
  rec_t q_r;
  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= d;
    end
  end
  assign q = q_r;
endmodule

// File: rtl/cdc_chain.sv
// Row of record cells; cell 0 is the oldest record.
module cdc_chain import cdc_pkg::*; (
  input  logic       clk,
  input  chain_ctl_t ctl,
  output rec_t       head
);
  rec_t q [MaxRecords];
  rec_t d [MaxRecords];
  logic ld [MaxRecords];
  always_comb begin
    for (int i = 0; i < MaxRecords; i++) begin
      d[i] = (i == MaxRecords - 1) ? q[0] : q[i + 1];
      ld[i] = 1'b0;
      if (ctl.pop) begin
        ld[i] = 1'b1;
      end else if (ctl.rotate) begin
        // rotate only among live cells
        ld[i] = (CountW'(i) < ctl.count);
        if (CountW'(i) == ctl.count - 1'b1) begin
          d[i] = q[0];
        end
      end else if (ctl.push && CountW'(i) == ctl.count) begin
        ld[i] = 1'b1;
        d[i] = ctl.rec;
      end
    end
  end
  for (genvar g = 0; g < MaxRecords; g++) begin : g_cell
    cdc_cell u_cell (.clk(clk), .load(ld[g]), .d(d[g]), .q(q[g]));
  end
  assign head = q[0];
endmodule

// File: rtl/coap_dedup_message_cache_unit.sv
// Top level of the CoAP message deduplication cache.
// Records sit in a row of cells, oldest in cell 0; expiry and eviction shift
// the row toward the head one record per cycle, and a search rotates the live
// records past cell 0 one per cycle, a full turn so age order is restored.
// A lookup first drops expired records, then searches the live records; an add
// also evicts records for room before it is written at the tail. A too-large add
// answers in the cycle after its transfer. Slot numbers are the physical slots
// of a circular store, tracked by a head pointer. One item at a time; the
// result sits in an output register, and the next item is taken only once
// that result is free or in the cycle that it is accepted.
module coap_dedup_message_cache_unit import cdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data,     // entry_lifetime_ms
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] endpoint_handle, [31:16] message_id, [43:32] message_length,
  // [75:44] now_ms, [79:76] zero
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,     // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [8:3] slot, [15:9] evicted_count
  output logic [15:0] out_tdata
);
  typedef enum logic [2:0] {S_IDLE, S_EXPIRE, S_SEARCH, S_EVICT, S_DONE} state_t;
  state_t state_r;
  logic [23:0] life_r;
  logic op_r;
  logic [31:0] key_r, now_r;
  logic [CostW-1:0] cost_r;
  logic [SlotW-1:0] head_r, slot_r;
  logic [CountW-1:0] count_r, idx_r;
  logic [BytesW-1:0] bytes_r;
  logic [6:0] evict_r;
  logic found_r;
  logic [2:0] status_r;
  logic ovalid_r;
  logic ovalid_nxt;
  rec_t head_rec;
  chain_ctl_t ctl;

  logic [11:0] len;
  logic [CostW-1:0] in_cost;
  logic too_large;
  assign len = in_tdata[43:32];
  // round the length up to the alignment in the wide cost width
  assign in_cost = CostW'(RecordOverhead + LengthFieldBytes)
                 + CostW'(((CostW'(len) + CostW'(AlignBytes - 1)) / AlignBytes)
                          * AlignBytes);
  assign too_large = !in_tuser && (in_cost > CostW'(BufferBytes));

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && (!ovalid_r || out_tready);
  assign out_tvalid = ovalid_r;
  assign out_tdata = {evict_r, slot_r, status_r};

  logic expired, need_room;
  logic [31:0] diff;
  assign diff = head_rec.expiry - now_r;
  assign expired = (count_r != '0) && diff[31];
  assign need_room = (count_r != '0) &&
    ((BytesW+1)'(BufferBytes) - {1'b0, bytes_r} < (BytesW+1)'(cost_r) ||
     count_r >= CountW'(MaxRecords));

  // Drop the result on its transfer, raise it for a too-large add or at the end.
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (out_tvalid && out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (state_r == S_IDLE && in_tvalid && in_tready && too_large) begin
      ovalid_nxt = 1'b1;
    end
    if (state_r == S_DONE && !ovalid_r) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_comb begin
    ctl = '0;
    ctl.count = count_r;
    ctl.rec.key = key_r;
    ctl.rec.expiry = now_r + {8'd0, life_r};
    ctl.rec.cost = cost_r;
    unique case (state_r)
      S_EXPIRE: ctl.pop = expired;
      S_SEARCH: ctl.rotate = (idx_r < count_r);
      S_EVICT:  begin
        ctl.pop = need_room;
        ctl.push = !need_room;
      end
      default: ;
    endcase
  end

  cdc_chain u_chain (.clk(clk), .ctl(ctl), .head(head_rec));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      life_r <= 24'd247000;
      head_r <= '0;
      count_r <= '0;
      bytes_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        life_r <= cfg_data;
      end
      ovalid_r <= ovalid_nxt;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          op_r <= in_tuser;
          key_r <= {in_tdata[15:0], in_tdata[31:16]};
          now_r <= in_tdata[75:44];
          cost_r <= in_cost;
          evict_r <= '0;
          idx_r <= '0;
          found_r <= 1'b0;
          slot_r <= '0;
          if (too_large) begin
            // too large: answer at once, state untouched
            status_r <= StTooLarge;
          end else begin
            state_r <= S_EXPIRE;
          end
        end
        S_EXPIRE: begin
          if (expired) begin
            bytes_r <= bytes_r - BytesW'(head_rec.cost);
            head_r <= head_r + 1'b1;
            count_r <= count_r - 1'b1;
            evict_r <= evict_r + 1'b1;
          end else begin
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (idx_r < count_r) begin
            if (!found_r && head_rec.key == key_r) begin
              found_r <= 1'b1;
              slot_r <= head_r + idx_r[SlotW-1:0];
            end
            idx_r <= idx_r + 1'b1;
          end else if (op_r) begin
            status_r <= found_r ? StHit : StMiss;
            state_r <= S_DONE;
          end else if (found_r) begin
            status_r <= StDuplicate;
            state_r <= S_DONE;
          end else begin
            state_r <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (need_room) begin
            bytes_r <= bytes_r - BytesW'(head_rec.cost);
            head_r <= head_r + 1'b1;
            count_r <= count_r - 1'b1;
            evict_r <= evict_r + 1'b1;
          end else begin
            slot_r <= head_r + count_r[SlotW-1:0];
            count_r <= count_r + 1'b1;
            bytes_r <= bytes_r + BytesW'(cost_r);
            status_r <= StAdded;
            state_r <= S_DONE;
          end
        end
        S_DONE: if (!ovalid_r) begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/cdc_checker.sv
// Port-level checker for the deduplication cache, bound to the top level.
`include "coap_dedup_message_cache_unit_macros.svh"
module cdc_checker import cdc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);
  logic [2:0] st;
  logic [6:0] evicted;
  logic no_slot;
  logic out_stall;
  assign st = out_tdata[2:0];
  assign evicted = out_tdata[15:9];
  assign no_slot = out_tvalid && (st == StMiss || st == StTooLarge);
  assign out_stall = out_tvalid && !out_tready;

  `CDC_ASSERT_IMPL(a_status_legal, clk, rst_n, out_tvalid, st <= StMiss, "bad status")
  `CDC_ASSERT_IMPL(a_miss_slot0, clk, rst_n, no_slot, out_tdata[8:3] == 6'd0, "slot not zero")
  `CDC_ASSERT_IMPL(a_evict_max, clk, rst_n, out_tvalid, evicted <= 7'(MaxRecords), "evicted big")
  `CDC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata), "held")
  `CDC_ASSERT_IMPL(a_in_block, clk, rst_n, out_stall, !(in_tvalid && in_tready), "input taken")
endmodule
bind coap_dedup_message_cache_unit cdc_checker u_cdc_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
